// File: hw/rtl/jhd_pkg.sv
// ----------------------------------------------------------------------------
// jhd_pkg
// Shared types, constants and character helpers for the Johab text decoder.
// ----------------------------------------------------------------------------
package jhd_pkg;

    localparam logic [15:0] SYL_BASE   = 16'hAC00;
    localparam logic [15:0] PAIR_LO    = 16'h8400;
    localparam logic [15:0] PAIR_HI    = 16'hD3FF;
    localparam logic [7:0]  HIGH_MARK  = 8'h80;
    localparam logic [4:0]  FIELD_MASK = 5'h1F;
    localparam logic [7:0]  SPACE_CHAR = 8'h20;
    localparam logic [7:0]  SPACE_MAX  = 8'hFF;
    localparam logic [4:0]  INI_MIN    = 5'd2;
    localparam logic [4:0]  INI_MAX    = 5'd20;

    typedef enum logic [1:0] {
        TK_ASCII,
        TK_PAIR,
        TK_END
    } tok_kind_t;

    // one queued result: ascii byte, raw johab pair, or the string end
    typedef struct packed {
        tok_kind_t   kind;
        logic [15:0] data;
        logic [7:0]  spaces;
    } token_t;

    function automatic logic is_alpha(input logic [7:0] b);
        return (b >= 8'h61 && b <= 8'h7A) || (b >= 8'h41 && b <= 8'h5A);
    endfunction

    function automatic logic is_alnum(input logic [7:0] b);
        return is_alpha(b) || (b >= 8'h30 && b <= 8'h39);
    endfunction

    function automatic logic is_listed(input logic [7:0] b);
        return b inside {8'h20, 8'h2D, 8'h3F, 8'h21, 8'h2E, 8'h2C, 8'h28, 8'h29,
                         8'h5B, 8'h5D, 8'h2F, 8'h2A, 8'h3A, 8'h3B, 8'h27, 8'h22,
                         8'h40};
    endfunction

    function automatic logic med_ok(input logic [4:0] m);
        return m inside {[5'd3:5'd7], [5'd10:5'd15], [5'd18:5'd23], [5'd26:5'd29]};
    endfunction

    function automatic logic [4:0] med_idx(input logic [4:0] m);
        logic [4:0] r;
        if (m <= 5'd7)
            r = m - 5'd3;
        else if (m <= 5'd15)
            r = m - 5'd5;
        else if (m <= 5'd23)
            r = m - 5'd7;
        else
            r = m - 5'd9;
        return r;
    endfunction

    function automatic logic fin_ok(input logic [4:0] f);
        return f inside {[5'd1:5'd17], [5'd19:5'd29]};
    endfunction

    function automatic logic [4:0] fin_idx(input logic [4:0] f);
        return (f <= 5'd17) ? f - 5'd1 : f - 5'd2;
    endfunction

    function automatic logic pair_ok(input logic [15:0] code);
        logic [4:0] ini;
        ini = (code[14:10]) & FIELD_MASK;
        return code >= PAIR_LO && code <= PAIR_HI && ini >= INI_MIN && ini <= INI_MAX
            && med_ok(code[9:5] & FIELD_MASK) && fin_ok(code[4:0] & FIELD_MASK);
    endfunction

endpackage

// File: hw/rtl/jhd_byte_if.sv
// ----------------------------------------------------------------------------
// jhd_byte_if
// Raw byte channel: one Johab byte and its end-of-string flag per beat.
// ----------------------------------------------------------------------------
interface jhd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       last_byte;

    modport source (output valid, output in_byte, output last_byte, input ready);
    modport sink   (input valid, input in_byte, input last_byte, output ready);
endinterface

// File: hw/rtl/jhd_char_if.sv
// ----------------------------------------------------------------------------
// jhd_char_if
// Decoded character channel: one UTF-16 character or end item per beat.
// ----------------------------------------------------------------------------
interface jhd_char_if;
    logic        valid;
    logic        ready;
    logic [15:0] code_point;
    logic [7:0]  spaces_before;
    logic        end_of_string;

    modport source (output valid, output code_point, output spaces_before,
                    output end_of_string, input ready);
    modport sink   (input valid, input code_point, input spaces_before,
                    input end_of_string, output ready);
endinterface

// File: hw/rtl/johab_hangul_text_decoder.sv
// ----------------------------------------------------------------------------
// johab_hangul_text_decoder
// Johab byte string to UTF-16 Hangul/ascii characters with space trimming.
// ----------------------------------------------------------------------------
// Takes one raw byte per beat on raw and gives decoded characters on text,
// each with the count of inner spaces before it, and one end item per string.
// A byte that yields at most one result is taken every cycle while the queue
// has room; a byte that yields two or three results holds raw while the front
// end pushes its leftover tokens into the queue, which takes one token a cycle
// while it is not full. A character reaches text at the earliest through the
// queue, composer stage and output register. Lead bytes, and letters that do
// not follow an alphanumeric, wait for the following byte before they resolve.
module johab_hangul_text_decoder
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic       clk,
    input  logic       rst_n,
    jhd_byte_if.sink   raw,
    jhd_char_if.source text
);

    logic            push_valid;
    logic            push_ready;
    jhd_pkg::token_t push_tok;
    logic            pop_valid;
    logic            pop_ready;
    jhd_pkg::token_t pop_tok;

    jhd_front u_front
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .raw        (raw),
        .push_valid (push_valid),
        .push_tok   (push_tok),
        .push_ready (push_ready)
    );

    jhd_queue #(.DEPTH(QUEUE_DEPTH)) u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_tok   (push_tok),
        .push_ready (push_ready),
        .pop_valid  (pop_valid),
        .pop_tok    (pop_tok),
        .pop_ready  (pop_ready)
    );

    jhd_back u_back
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .pop_valid (pop_valid),
        .pop_tok   (pop_tok),
        .pop_ready (pop_ready),
        .text      (text)
    );

    // only decodable pairs ever reach the composer
    a_pair_ok: assert property (@(posedge clk) disable iff (!rst_n)
        pop_valid && pop_ready && pop_tok.kind == jhd_pkg::TK_PAIR
        |-> jhd_pkg::pair_ok(pop_tok.data))
        else $error("undecodable pair queued");

    a_end_clean: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && text.end_of_string
        |-> text.code_point == 16'd0 && text.spaces_before == 8'd0)
        else $error("end item carries data");

    a_syl_range: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && !text.end_of_string && text.code_point[15:8] != 8'd0
        |-> text.code_point >= 16'hAC00 && text.code_point <= 16'hD7A3)
        else $error("syllable out of range");

    // spaces are always folded into a count, never sent as characters
    a_no_space: assert property (@(posedge clk) disable iff (!rst_n)
        text.valid && !text.end_of_string |-> text.code_point != 16'h0020
        && text.code_point != 16'h0000)
        else $error("space or null character sent");

endmodule

// File: hw/rtl/jhd_front.sv
// ----------------------------------------------------------------------------
// jhd_front
// Accepts raw bytes, tracks pairing, lookahead and space state, and pushes
// up to three result tokens per byte toward the queue.
// ----------------------------------------------------------------------------
module jhd_front
(
    input  logic               clk,
    input  logic               rst_n,
    jhd_byte_if.sink           raw,
    output logic               push_valid,
    output jhd_pkg::token_t    push_tok,
    input  logic               push_ready
);

    logic            held_valid_reg, held_valid_next;
    logic [7:0]      held_byte_reg, held_byte_next;
    logic            prev_alnum_reg, prev_alnum_next;
    logic            seen_reg, seen_next;
    logic [7:0]      spaces_reg, spaces_next;
    jhd_pkg::token_t pend_reg [2];
    jhd_pkg::token_t pend_next [2];
    logic [1:0]      pcnt_reg, pcnt_next;

    logic            accept;
    jhd_pkg::token_t list [3];
    logic [1:0]      ntok;

    // per-byte decisions
    logic            a_v;
    jhd_pkg::token_t a_tok;
    logic            a_alnum;
    logic            b_v;
    logic            b_space;
    logic            do_b;
    logic            pa_mid;
    logic            seen_mid;
    logic [7:0]      spaces_mid;
    logic [15:0]     pair_code;

    assign raw.ready = (pcnt_reg == 2'd0) && push_ready;
    assign accept    = raw.valid && raw.ready;
    assign pair_code = {held_byte_reg, raw.in_byte};

    always_comb
    begin
        a_v             = 1'b0;
        a_alnum         = 1'b0;
        a_tok           = '{kind: jhd_pkg::TK_ASCII, data: {8'd0, held_byte_reg},
                            spaces: spaces_reg};
        b_v             = 1'b0;
        b_space         = 1'b0;
        do_b            = 1'b1;
        held_valid_next = 1'b0;
        held_byte_next  = 8'd0;

        // resolve the byte held from the previous beat
        if (held_valid_reg)
        begin
            if (held_byte_reg >= jhd_pkg::HIGH_MARK)
            begin
                do_b = 1'b0;
                if (jhd_pkg::pair_ok(pair_code))
                begin
                    a_v        = 1'b1;
                    a_tok.kind = jhd_pkg::TK_PAIR;
                    a_tok.data = pair_code;
                end
            end
            else if (jhd_pkg::is_alnum(raw.in_byte))
            begin
                a_v     = 1'b1;
                a_alnum = 1'b1;
            end
        end

        pa_mid     = a_v ? a_alnum : prev_alnum_reg;
        seen_mid   = a_v ? 1'b1 : seen_reg;
        spaces_mid = a_v ? 8'd0 : spaces_reg;

        if (do_b)
        begin
            if (raw.in_byte >= jhd_pkg::HIGH_MARK)
            begin
                held_valid_next = !raw.last_byte;
                held_byte_next  = raw.last_byte ? 8'd0 : raw.in_byte;
            end
            else if (raw.in_byte == 8'd0)
            begin
                b_v = 1'b0;
            end
            else if (jhd_pkg::is_alpha(raw.in_byte))
            begin
                if (pa_mid)
                    b_v = 1'b1;
                else if (!raw.last_byte)
                begin
                    held_valid_next = 1'b1;
                    held_byte_next  = raw.in_byte;
                end
            end
            else if (jhd_pkg::is_alnum(raw.in_byte) || jhd_pkg::is_listed(raw.in_byte))
            begin
                b_v = 1'b1;
            end
        end

        b_space         = b_v && (raw.in_byte == jhd_pkg::SPACE_CHAR);
        prev_alnum_next = pa_mid;
        seen_next       = seen_mid;
        spaces_next     = spaces_mid;
        if (b_space)
        begin
            prev_alnum_next = 1'b0;
            if (seen_mid && spaces_mid != jhd_pkg::SPACE_MAX)
                spaces_next = spaces_mid + 8'd1;
        end
        else if (b_v)
        begin
            prev_alnum_next = jhd_pkg::is_alnum(raw.in_byte);
            seen_next       = 1'b1;
            spaces_next     = 8'd0;
        end

        // order the tokens of this beat
        ntok = 2'd0;
        for (int i = 0; i < 3; i++)
            list[i] = '{kind: jhd_pkg::TK_END, data: 16'd0, spaces: 8'd0};
        if (a_v)
        begin
            list[ntok] = a_tok;
            ntok       = ntok + 2'd1;
        end
        if (b_v && !b_space)
        begin
            list[ntok] = '{kind: jhd_pkg::TK_ASCII, data: {8'd0, raw.in_byte},
                           spaces: spaces_mid};
            ntok       = ntok + 2'd1;
        end
        if (raw.last_byte)
        begin
            list[ntok] = '{kind: jhd_pkg::TK_END, data: 16'd0, spaces: 8'd0};
            ntok       = ntok + 2'd1;
            held_valid_next = 1'b0;
            held_byte_next  = 8'd0;
            prev_alnum_next = 1'b0;
            seen_next       = 1'b0;
            spaces_next     = 8'd0;
        end
    end

    // push side: leftover tokens first, else the first token of the new byte
    always_comb
    begin
        pend_next[0] = pend_reg[0];
        pend_next[1] = pend_reg[1];
        pcnt_next    = pcnt_reg;
        if (pcnt_reg != 2'd0)
        begin
            push_valid = 1'b1;
            push_tok   = pend_reg[0];
            if (push_ready)
            begin
                pend_next[0] = pend_reg[1];
                pcnt_next    = pcnt_reg - 2'd1;
            end
        end
        else
        begin
            push_valid = accept && (ntok != 2'd0);
            push_tok   = list[0];
            if (accept && ntok != 2'd0)
            begin
                pend_next[0] = list[1];
                pend_next[1] = list[2];
                pcnt_next    = ntok - 2'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
            held_byte_reg  <= 8'd0;
            prev_alnum_reg <= 1'b0;
            seen_reg       <= 1'b0;
            spaces_reg     <= 8'd0;
            pcnt_reg       <= 2'd0;
        end
        else
        begin
            if (accept)
            begin
                held_valid_reg <= held_valid_next;
                held_byte_reg  <= held_byte_next;
                prev_alnum_reg <= prev_alnum_next;
                seen_reg       <= seen_next;
                spaces_reg     <= spaces_next;
            end
            pcnt_reg <= pcnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        pend_reg[0] <= pend_next[0];
        pend_reg[1] <= pend_next[1];
    end

endmodule

// File: hw/rtl/jhd_queue.sv
// ----------------------------------------------------------------------------
// jhd_queue
// Small token queue between the front and back ends.
// ----------------------------------------------------------------------------
module jhd_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push_valid,
    input  jhd_pkg::token_t push_tok,
    output logic            push_ready,
    output logic            pop_valid,
    output jhd_pkg::token_t pop_tok,
    input  logic            pop_ready
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    jhd_pkg::token_t store_reg [DEPTH];
    logic [AW-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [AW-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CW-1:0]   count_reg, count_next;
    logic            do_push;
    logic            do_pop;

    assign push_ready = (count_reg != CW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_tok    = store_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == AW'(DEPTH - 1)) ? '0 : wr_ptr_reg + AW'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == AW'(DEPTH - 1)) ? '0 : rd_ptr_reg + AW'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CW'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CW'(1);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            store_reg[wr_ptr_reg] <= push_tok;
    end

endmodule

// File: hw/rtl/jhd_back.sv
// ----------------------------------------------------------------------------
// jhd_back
// Turns queued tokens into characters: Johab pairs go through a two-stage
// syllable composer, ascii and end items ride along.
// ----------------------------------------------------------------------------
module jhd_back
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               pop_valid,
    input  jhd_pkg::token_t    pop_tok,
    output logic               pop_ready,
    jhd_char_if.source         text
);

    logic                s1_valid_reg;
    jhd_pkg::tok_kind_t  s1_kind_reg;
    logic [15:0]         s1_data_reg;
    logic [8:0]          s1_idx_reg;
    logic [4:0]          s1_fin_reg;
    logic [7:0]          s1_spaces_reg;

    logic                s2_valid_reg;
    logic [15:0]         s2_cp_reg;
    logic [7:0]          s2_spaces_reg;
    logic                s2_end_reg;

    logic                s2_en;
    logic                s1_en;
    logic [4:0]          ini_off;
    logic [8:0]          idx_next;
    logic [15:0]         cp_next;

    assign s2_en     = !s2_valid_reg || text.ready;
    assign s1_en     = !s1_valid_reg || s2_en;
    assign pop_ready = s1_en;

    // syllable index before the final consonant: (ini - 2) * 21 + med
    assign ini_off  = pop_tok.data[14:10] - jhd_pkg::INI_MIN;
    assign idx_next = 9'(9'(ini_off) * 9'd21) + 9'(jhd_pkg::med_idx(pop_tok.data[9:5]));

    always_comb
    begin
        case (s1_kind_reg)
            jhd_pkg::TK_PAIR:  cp_next = jhd_pkg::SYL_BASE + 16'(16'(s1_idx_reg) * 16'd28)
                                         + 16'(s1_fin_reg);
            jhd_pkg::TK_ASCII: cp_next = s1_data_reg;
            jhd_pkg::TK_END:   cp_next = 16'd0;
            default:           cp_next = 16'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
        end
        else
        begin
            if (s1_en)
                s1_valid_reg <= pop_valid;
            if (s2_en)
                s2_valid_reg <= s1_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (s1_en)
        begin
            s1_kind_reg   <= pop_tok.kind;
            s1_data_reg   <= pop_tok.data;
            s1_idx_reg    <= idx_next;
            s1_fin_reg    <= jhd_pkg::fin_idx(pop_tok.data[4:0]);
            s1_spaces_reg <= pop_tok.spaces;
        end
        if (s2_en)
        begin
            s2_cp_reg     <= cp_next;
            s2_spaces_reg <= s1_spaces_reg;
            s2_end_reg    <= (s1_kind_reg == jhd_pkg::TK_END);
        end
    end

    assign text.valid         = s2_valid_reg;
    assign text.code_point    = s2_cp_reg;
    assign text.spaces_before = s2_spaces_reg;
    assign text.end_of_string = s2_end_reg;

endmodule
